// ===== src/sesp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted edge pair search package
// Shared constants, widths, codes and types of the sorted edge pair search core.
// ----------------------------------------------------------------------------
`default_nettype none

package sesp_pkg;

    // Sizing of the edge lists.
    localparam int EDGES_PER_SLOT = 1024;
    localparam int SLOT_COUNT     = 16;
    localparam int NODE_WIDTH     = 16;

    // Width of the node number fields on the stream.
    localparam int NODE_FIELD_W = 16;
    // Node numbers are kept in their low NODE_WIDTH bits.
    localparam int KEY_W        = (NODE_WIDTH < NODE_FIELD_W) ? NODE_WIDTH : NODE_FIELD_W;
    // Position within one list and edge count of one list.
    localparam int POS_W        = $clog2(EDGES_PER_SLOT);
    localparam int CNT_W        = $clog2(EDGES_PER_SLOT + 1);
    localparam int SLOT_IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int STORE_DEPTH  = SLOT_COUNT * EDGES_PER_SLOT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    // One store word holds destination (upper half) and source (lower half).
    localparam int EDGE_W       = 2 * KEY_W;

    // Fixed widths of the stream fields.
    localparam int MODE_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int POS_OUT_W  = 10;

    // Item kinds carried on the input tuser.
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result of one item.
    typedef struct packed {
        logic             full_res;
        logic [POS_W-1:0] position;
        logic             found;
    } res_t;

    // Flat store address of entry idx in the list of slot s.
    function automatic logic [ADDR_W-1:0] edge_addr(input logic [SLOT_IDX_W-1:0] s,
                                                    input logic [POS_W-1:0]      idx);
        return ADDR_W'(32'(s) * EDGES_PER_SLOT + 32'(idx));
    endfunction

endpackage

`default_nettype wire

// ===== src/sesp_edge_ram.sv =====
// ----------------------------------------------------------------------------
// Edge store RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sesp_edge_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/sesp_search_ctrl.sv =====
// ----------------------------------------------------------------------------
// Search controller
// Keeps the per-slot edge counts and sequences append, clear and bisection.
// ----------------------------------------------------------------------------
`default_nettype none

module sesp_search_ctrl
    import sesp_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Item input
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [MODE_W-1:0]       in_mode,
    input  wire logic [SLOT_W-1:0]       in_slot,
    input  wire logic [NODE_FIELD_W-1:0] in_from_node,
    input  wire logic [NODE_FIELD_W-1:0] in_to_node,
    // Result output
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output res_t                         res,
    // Edge store
    output logic                         ram_wr_en,
    output logic [ADDR_W-1:0]            ram_wr_addr,
    output logic [EDGE_W-1:0]            ram_wr_data,
    output logic [ADDR_W-1:0]            ram_rd_addr,
    input  wire logic [EDGE_W-1:0]       ram_rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST_RD,
        ST_FIRST_CHK,
        ST_LAST_CHK,
        ST_BIS_ISSUE,
        ST_BIS_CHK,
        ST_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg [SLOT_COUNT];
    logic [CNT_W-1:0]      cnt_next [SLOT_COUNT];
    logic [SLOT_IDX_W-1:0] slot_reg, slot_next;
    logic [KEY_W-1:0]      src_reg, src_next;
    logic [KEY_W-1:0]      dst_reg, dst_next;
    logic [POS_W-1:0]      lb_reg, lb_next;
    logic [POS_W-1:0]      ub_reg, ub_next;
    logic [POS_W-1:0]      mid_reg, mid_next;
    logic                  last_reg, last_next;
    res_t                  res_reg, res_next;

    logic                  in_accept;
    logic [SLOT_IDX_W-1:0] in_sidx;
    logic                  in_slot_ok;
    logic [CNT_W-1:0]      in_cnt;
    logic [KEY_W-1:0]      in_src;
    logic [KEY_W-1:0]      in_dst;
    logic [KEY_W-1:0]      rd_src;
    logic [KEY_W-1:0]      rd_dst;
    logic                  rd_hit;
    logic                  rd_below;
    logic [POS_W-1:0]      span;
    logic [POS_W-1:0]      mid_calc;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign in_sidx    = SLOT_IDX_W'(in_slot);
    assign in_slot_ok = (32'(in_slot) < SLOT_COUNT);
    assign in_cnt     = cnt_reg[in_sidx];
    assign in_src     = in_from_node[KEY_W-1:0];
    assign in_dst     = in_to_node[KEY_W-1:0];

    // Compare the entry read from the store against the searched edge.
    assign rd_src   = ram_rd_data[KEY_W-1:0];
    assign rd_dst   = ram_rd_data[EDGE_W-1:KEY_W];
    assign rd_hit   = (rd_src == src_reg) && (rd_dst == dst_reg);
    assign rd_below = (rd_dst < dst_reg) || ((rd_dst == dst_reg) && (rd_src < src_reg));

    // Midpoint of the current bounds, rounded down.
    assign span     = ub_reg - lb_reg;
    assign mid_calc = lb_reg + (span >> 1);

    // An append writes at the end of the slot's list.
    assign ram_wr_en   = in_accept && (in_mode == MODE_APPEND) && in_slot_ok &&
                         (32'(in_cnt) < EDGES_PER_SLOT);
    assign ram_wr_addr = edge_addr(in_sidx, POS_W'(in_cnt));
    assign ram_wr_data = {in_dst, in_src};

    // Read address per search step.
    always_comb begin
        case (state_reg)
            ST_FIRST_RD:  ram_rd_addr = edge_addr(slot_reg, lb_reg);
            ST_FIRST_CHK: ram_rd_addr = edge_addr(slot_reg, ub_reg);
            ST_BIS_ISSUE: ram_rd_addr = edge_addr(slot_reg, mid_calc);
            default:      ram_rd_addr = edge_addr(slot_reg, mid_reg);
        endcase
    end

    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    // Next-state and datapath logic.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        lb_next    = lb_reg;
        ub_next    = ub_reg;
        mid_next   = mid_reg;
        last_next  = last_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    slot_next  = in_sidx;
                    src_next   = in_src;
                    dst_next   = in_dst;
                    res_next   = '0;
                    state_next = ST_RESULT;
                    case (in_mode)
                        MODE_QUERY: begin
                            if (in_slot_ok && (in_cnt != '0)) begin
                                lb_next    = '0;
                                ub_next    = POS_W'(in_cnt - CNT_W'(1));
                                state_next = ST_FIRST_RD;
                            end
                        end
                        MODE_APPEND: begin
                            if (in_slot_ok) begin
                                if (32'(in_cnt) >= EDGES_PER_SLOT) begin
                                    res_next.full_res = 1'b1;
                                end else begin
                                    cnt_next[in_sidx] = in_cnt + CNT_W'(1);
                                    res_next.found    = 1'b1;
                                    res_next.position = POS_W'(in_cnt);
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            if (in_slot_ok) begin
                                cnt_next[in_sidx] = '0;
                            end
                        end
                        default: begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            ST_FIRST_RD: begin
                state_next = ST_FIRST_CHK;
            end
            ST_FIRST_CHK: begin
                // First entry is on the read port; the last one is requested.
                if (rd_hit) begin
                    res_next.found    = 1'b1;
                    res_next.position = lb_reg;
                    state_next        = ST_RESULT;
                end else begin
                    state_next = ST_LAST_CHK;
                end
            end
            ST_LAST_CHK: begin
                if (rd_hit) begin
                    res_next.found    = 1'b1;
                    res_next.position = ub_reg;
                    state_next        = ST_RESULT;
                end else begin
                    state_next = ST_BIS_ISSUE;
                end
            end
            ST_BIS_ISSUE: begin
                mid_next   = mid_calc;
                last_next  = (span <= POS_W'(1));
                state_next = ST_BIS_CHK;
            end
            ST_BIS_CHK: begin
                if (rd_hit) begin
                    res_next.found    = 1'b1;
                    res_next.position = mid_reg;
                    state_next        = ST_RESULT;
                end else begin
                    if (rd_below) begin
                        lb_next = mid_reg;
                    end else begin
                        ub_next = mid_reg;
                    end
                    state_next = last_reg ? ST_RESULT : ST_BIS_ISSUE;
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counts and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        slot_reg <= slot_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        lb_reg   <= lb_next;
        ub_reg   <= ub_next;
        mid_reg  <= mid_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

`ifndef SYNTH
    // The bounds never cross while the bisection runs.
    a_bounds_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BIS_ISSUE) |-> (lb_reg <= ub_reg))
        else $error("bisection bounds crossed");

    // A slot's count never exceeds the list capacity.
    a_count_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(in_cnt) <= EDGES_PER_SLOT))
        else $error("slot edge count above capacity");

    // An accepted item keeps the input closed until its result is handed on.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !in_ready)
        else $error("input reopened while an item is in work");

    // A found query position lies inside the slot's list.
    a_found_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_reg.found) |-> (32'(res_reg.position) < 32'(cnt_reg[slot_reg])))
        else $error("reported position outside the list");
`endif

endmodule

`default_nettype wire

// ===== src/sorted_edge_pair_search_core.sv =====
// Append, clear, other items and queries on empty lists pass straight to the result;
// a query checks the first and then the last entry of the list, ends on a hit, and else runs
// bisection steps, each a read and compare on the store port.
// Throughput: one item at a time; the next item is taken after the result is handed on.
// Reset (aresetn low, synchronous) empties every slot and the output register;
// the edge store keeps undefined contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// Sorted edge pair search core
// Per-slot sorted edge lists with append, clear and bisection query items.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_edge_pair_search_core
    import sesp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Item input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: slot[3:0], from_node[19:4], to_node[35:20], zero[39:36]
    input  wire logic [39:0] s_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]  s_tuser,
    // Result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: found[0], position[10:1], full_res[11], zero[15:12]
    output logic [15:0]      m_tdata
);

    res_t              res;
    logic              res_valid;
    logic              res_ready;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [EDGE_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [EDGE_W-1:0] ram_rd_data;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;

    sesp_search_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_mode      (s_tuser),
        .in_slot      (s_tdata[3:0]),
        .in_from_node (s_tdata[19:4]),
        .in_to_node   (s_tdata[35:20]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    sesp_edge_ram #(
        .DATA_W (EDGE_W),
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_edge_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_tdata_reg <= {4'b0, res.full_res, POS_OUT_W'(res.position), res.found};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
